[rtl/trct_pkg.sv]
// Shared types and constants for the tunnel relay connection table.
package trct_pkg;

    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int MAX_RESULTS       = 16;
    localparam int CNT_W             = $clog2(MAX_RESULTS + 1);

    localparam logic [15:0] ECHO_SOCKET     = 16'h0002;
    localparam logic [31:0] BCAST_HOST      = 32'hffff_ffff;
    localparam logic [31:0] REG_HOST        = 32'h0000_0000;
    localparam logic [15:0] DEFAULT_TIMEOUT = 16'd900;

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    localparam logic ACT_ACK = 1'b0;
    localparam logic ACT_FWD = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] dest_socket;
        logic [31:0] dest_host;
        logic [15:0] dest_port;
        logic [31:0] src_host;
        logic [15:0] src_port;
        logic [31:0] udp_host;
        logic [15:0] udp_port;
    } t_req;

    typedef struct packed {
        logic        action;
        logic [3:0]  slot;
        logic [31:0] peer_host;
        logic [15:0] peer_port;
        logic        last;
    } t_result;

    // One table slot as kept in the memory: host in the upper 32 bits.
    typedef struct packed {
        logic [47:0] addr;
        logic [15:0] timeout;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic conn_set;
        logic conn_clr;
    } t_store_cmd;

    typedef struct packed {
        logic   conn;
        t_entry entry;
    } t_store_rsp;

endpackage

[rtl/trct_store.sv]
// Slot memory (address and timeout) plus per-slot connected flags.
module trct_store #(
    parameter int TABLE_ENTRIES = trct_pkg::DEF_TABLE_ENTRIES,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  trct_pkg::t_store_cmd  i_cmd,
    input  logic [IDX_W-1:0]      i_rd_idx,
    input  logic [IDX_W-1:0]      i_wr_idx,
    input  trct_pkg::t_entry      i_wr_entry,
    output trct_pkg::t_store_rsp  o_rsp
);
    import trct_pkg::*;

    t_entry                   r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_conn;
    t_entry                   r_rd_entry;
    logic                     r_rd_conn;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_entry <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn    <= '0;
            r_rd_conn <= 1'b0;
        end else begin
            if (i_cmd.conn_set) begin
                r_conn[i_wr_idx] <= 1'b1;
            end else if (i_cmd.conn_clr) begin
                r_conn[i_wr_idx] <= 1'b0;
            end
            if (i_cmd.rd_en) begin
                r_rd_conn <= r_conn[i_rd_idx];
            end
        end
    end

    assign o_rsp.conn  = r_rd_conn;
    assign o_rsp.entry = r_rd_entry;

endmodule

[rtl/trct_engine.sv]
// Scan sequencer: walks every slot once unless ignored, updates slots, emits results.
module trct_engine #(
    parameter int TABLE_ENTRIES = trct_pkg::DEF_TABLE_ENTRIES,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  trct_pkg::t_req        i_req,
    input  logic [15:0]           i_timeout,
    output logic                  o_busy,
    output logic                  o_res_valid,
    output trct_pkg::t_result     o_res,
    output trct_pkg::t_store_cmd  o_cmd,
    output logic [IDX_W-1:0]      o_rd_idx,
    output logic [IDX_W-1:0]      o_wr_idx,
    output trct_pkg::t_entry      o_wr_entry,
    input  trct_pkg::t_store_rsp  i_rsp
);
    import trct_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;
    typedef enum logic [1:0] {OP_NONE, OP_TICK, OP_REG, OP_FWD} t_op;

    t_state           r_state;
    t_op              r_op;
    t_op              n_op;
    t_req             r_req;
    logic             r_rd_act;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic             r_match_v;
    logic [IDX_W-1:0] r_match_idx;
    logic             r_free_v;
    logic [IDX_W-1:0] r_free_idx;
    logic             r_pend_v;
    t_result          r_pend;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    t_result          r_out;

    logic        accept;
    logic [47:0] udp_addr;
    logic [47:0] src_addr;
    logic [47:0] dest_addr;
    logic [15:0] dec_t;
    logic        rcv;
    t_result     new_res;

    assign o_busy   = (r_state != S_IDLE);
    assign accept   = i_start && !o_busy;
    assign udp_addr  = {r_req.udp_host, r_req.udp_port};
    assign src_addr  = {r_req.src_host, r_req.src_port};
    assign dest_addr = {r_req.dest_host, r_req.dest_port};
    assign dec_t     = i_rsp.entry.timeout - 16'd1;

    always_comb begin
        if (i_req.req_type == REQ_TICK) begin
            n_op = OP_TICK;
        end else if (i_req.dest_socket == ECHO_SOCKET) begin
            n_op = (i_req.dest_host == REG_HOST) ? OP_REG : OP_NONE;
        end else begin
            n_op = OP_FWD;
        end
    end

    // Store port: one read per scan cycle; writes to the slot read or the OP_REG slot.
    always_comb begin
        o_cmd       = '0;
        o_cmd.rd_en = (r_state == S_SCAN) && r_rd_act;
        o_rd_idx    = r_rd_idx;
        o_wr_idx    = r_pidx;
        o_wr_entry  = i_rsp.entry;
        rcv         = 1'b0;
        case (r_op)
            OP_TICK: begin
                if (r_pv && i_rsp.conn) begin
                    o_cmd.wr_en            = 1'b1;
                    o_wr_entry.timeout     = dec_t;
                    o_cmd.conn_clr         = (dec_t == 16'd0);
                end
            end
            OP_FWD: begin
                if (r_pv && i_rsp.conn) begin
                    if (i_rsp.entry.addr == src_addr) begin
                        o_cmd.wr_en        = 1'b1;
                        o_wr_entry.timeout = i_timeout;
                    end else if (r_req.dest_host == BCAST_HOST
                                 || i_rsp.entry.addr == dest_addr) begin
                        rcv = 1'b1;
                    end
                end
            end
            OP_REG: begin
                if (r_state == S_FIN) begin
                    o_wr_entry.addr    = udp_addr;
                    o_wr_entry.timeout = i_timeout;
                    if (r_match_v) begin
                        o_cmd.wr_en = 1'b1;
                        o_wr_idx    = r_match_idx;
                    end else if (r_free_v) begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.conn_set = 1'b1;
                        o_wr_idx       = r_free_idx;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        new_res.action    = ACT_FWD;
        new_res.slot      = 4'(r_pidx);
        new_res.peer_host = i_rsp.entry.addr[47:16];
        new_res.peer_port = i_rsp.entry.addr[15:0];
        new_res.last      = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_NONE;
            r_rd_act    <= 1'b0;
            r_pv        <= 1'b0;
            r_match_v   <= 1'b0;
            r_free_v    <= 1'b0;
            r_pend_v    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            r_pv        <= o_cmd.rd_en;
            r_pidx      <= r_rd_idx;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_req     <= i_req;
                        r_op      <= n_op;
                        r_match_v <= 1'b0;
                        r_free_v  <= 1'b0;
                        r_pend_v  <= 1'b0;
                        r_cnt     <= '0;
                        r_rd_idx  <= '0;
                        r_rd_act  <= (n_op != OP_NONE);
                        r_state   <= (n_op == OP_NONE) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_act) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                        if (r_rd_idx == LAST_IDX) begin
                            r_rd_act <= 1'b0;
                        end
                    end
                    if (r_pv && r_op == OP_REG) begin
                        if (i_rsp.conn && i_rsp.entry.addr == udp_addr && !r_match_v) begin
                            r_match_v   <= 1'b1;
                            r_match_idx <= r_pidx;
                        end
                        if (!i_rsp.conn && !r_free_v) begin
                            r_free_v   <= 1'b1;
                            r_free_idx <= r_pidx;
                        end
                    end
                    // Hold each copy back one find so the final one can carry last.
                    if (rcv && r_cnt < CNT_W'(MAX_RESULTS)) begin
                        if (r_pend_v) begin
                            r_out_valid <= 1'b1;
                            r_out       <= r_pend;
                        end
                        r_pend   <= new_res;
                        r_pend_v <= 1'b1;
                        r_cnt    <= r_cnt + 1'b1;
                    end
                    if (r_pv && r_pidx == LAST_IDX) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_op == OP_REG && (r_match_v || r_free_v)) begin
                        r_out_valid     <= 1'b1;
                        r_out.action    <= ACT_ACK;
                        r_out.slot      <= r_match_v ? 4'(r_match_idx) : 4'(r_free_idx);
                        r_out.peer_host <= r_req.udp_host;
                        r_out.peer_port <= r_req.udp_port;
                        r_out.last      <= 1'b1;
                    end else if (r_op == OP_FWD && r_pend_v) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_pend;
                        r_out.last  <= 1'b1;
                    end
                    r_pend_v <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

[rtl/tunnel_relay_connection_table_top.sv]
// The last result of a transaction is registered in the finish state that follows the scan;
// forwarded copies come out as the scan finds them, each held back until the next find.
// A new packet or tick is accepted only while idle, so the scan that reads each slot once
// through the single memory read port paces transactions; an ignored socket-2 packet skips it.
// Results are one-cycle strobes that the receiver cannot stall.
// Reset (synchronous) frees all slots and loads the slot lifetime register with 900.
module tunnel_relay_connection_table_top #(
    parameter int TABLE_ENTRIES = trct_pkg::DEF_TABLE_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  trct_pkg::t_req    i_req,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    output logic              o_res_valid,
    output trct_pkg::t_result o_res
);
    import trct_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [15:0]      r_timeout;
    t_store_cmd       cmd;
    t_store_rsp       rsp;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= DEFAULT_TIMEOUT;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    trct_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (i_req),
        .i_timeout   (r_timeout),
        .o_busy      (busy),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .o_cmd       (cmd),
        .o_rd_idx    (rd_idx),
        .o_wr_idx    (wr_idx),
        .o_wr_entry  (wr_entry),
        .i_rsp       (rsp)
    );

    trct_store #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_rd_idx   (rd_idx),
        .i_wr_idx   (wr_idx),
        .i_wr_entry (wr_entry),
        .o_rsp      (rsp)
    );

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last |=> !o_res_valid)
        else $error("result after the last one of a transaction");

    a_ack_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.action == ACT_ACK |-> o_res.last)
        else $error("registration ack not marked last");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_res_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result emitted while idle");

endmodule
